FILE: rtl/pmu_pkg.sv
`default_nettype none

package pmu_pkg;

    localparam int MAX_TERMS_DEF = 32;
    localparam int COEF_W        = 32;
    localparam int DEG_W         = 6;
    localparam int PROD_W        = 2 * COEF_W;
    localparam int FRAC_W        = 16;
    localparam int M_TDATA_W     = 40;

    typedef enum logic [1:0] {
        ST_LOAD,
        ST_RUN,
        ST_DRAIN
    } pmu_state_t;

    typedef struct packed {
        logic             valid;
        logic             first;
        logic             last;
        logic             fin;
        logic             zero;
        logic [DEG_W-1:0] deg;
    } pmu_issue_t;

    typedef struct packed {
        logic                     valid;
        logic                     fin;
        logic                     sat;
        logic [DEG_W-1:0]         deg;
        logic signed [COEF_W-1:0] coef;
    } pmu_result_t;

endpackage

`default_nettype wire

FILE: rtl/pmu_mac.sv
`default_nettype none

module pmu_mac #(
    parameter int MAX_TERMS = pmu_pkg::MAX_TERMS_DEF,
    localparam int AW = (MAX_TERMS > 1) ? $clog2(MAX_TERMS) : 1
) (
    input  wire logic                             aclk,
    input  wire logic                             aresetn,
    input  wire logic                             wr_a_en,
    input  wire logic                             wr_b_en,
    input  wire logic [AW-1:0]                    wr_addr,
    input  wire logic signed [pmu_pkg::COEF_W-1:0] wr_data,
    input  wire logic [AW-1:0]                    rd_a_addr,
    input  wire logic [AW-1:0]                    rd_b_addr,
    input  wire pmu_pkg::pmu_issue_t              issue,
    input  wire logic                             adv,
    output pmu_pkg::pmu_result_t                  res
);

    localparam int ACC_W = pmu_pkg::PROD_W + AW;
    localparam int CW    = pmu_pkg::COEF_W;
    localparam int SAT_LO = pmu_pkg::FRAC_W + CW - 1;

    logic signed [CW-1:0] mem_a [MAX_TERMS];
    logic signed [CW-1:0] mem_b [MAX_TERMS];

    logic signed [CW-1:0]             rd_a_reg;
    logic signed [CW-1:0]             rd_b_reg;
    pmu_pkg::pmu_issue_t              tag1_reg;
    logic signed [pmu_pkg::PROD_W-1:0] prod_reg;
    pmu_pkg::pmu_issue_t              tag2_reg;
    logic signed [ACC_W-1:0]          acc_reg;
    logic signed [ACC_W-1:0]          acc_next;
    pmu_pkg::pmu_issue_t              tag3_reg;
    pmu_pkg::pmu_result_t             res_reg;
    pmu_pkg::pmu_result_t             res_next;

    logic signed [CW-1:0]             op_a;
    logic signed [CW-1:0]             op_b;
    logic signed [ACC_W-1:0]          biased;
    logic                             sat_hi;
    logic                             sat_lo;

    always_ff @(posedge aclk) begin
        if (wr_a_en) begin
            mem_a[wr_addr] <= wr_data;
        end
        if (wr_b_en) begin
            mem_b[wr_addr] <= wr_data;
        end
        if (adv) begin
            rd_a_reg <= mem_a[rd_a_addr];
            rd_b_reg <= mem_b[rd_b_addr];
        end
    end

    always_comb begin
        op_a     = tag1_reg.zero ? '0 : rd_a_reg;
        op_b     = tag1_reg.zero ? '0 : rd_b_reg;
        acc_next = tag2_reg.first ? ACC_W'(prod_reg) : acc_reg + ACC_W'(prod_reg);
        biased   = acc_reg + ACC_W'(1 << (pmu_pkg::FRAC_W - 1));
        sat_hi   = !biased[ACC_W-1] && (biased[ACC_W-2:SAT_LO] != '0);
        sat_lo   = biased[ACC_W-1] && !(&biased[ACC_W-2:SAT_LO]);
        res_next.valid = tag3_reg.valid && tag3_reg.last;
        res_next.fin   = tag3_reg.fin;
        res_next.deg   = tag3_reg.deg;
        res_next.sat   = sat_hi || sat_lo;
        priority if (sat_hi) begin
            res_next.coef = {1'b0, {(CW-1){1'b1}}};
        end else if (sat_lo) begin
            res_next.coef = {1'b1, {(CW-1){1'b0}}};
        end else begin
            res_next.coef = biased[SAT_LO:pmu_pkg::FRAC_W];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            tag1_reg.valid <= 1'b0;
            tag2_reg.valid <= 1'b0;
            tag3_reg.valid <= 1'b0;
            res_reg.valid  <= 1'b0;
        end else if (adv) begin
            tag1_reg <= issue;
            tag2_reg <= tag1_reg;
            prod_reg <= op_a * op_b;
            tag3_reg <= tag2_reg;
            if (tag2_reg.valid) begin
                acc_reg <= acc_next;
            end
            res_reg <= res_next;
        end
    end

    assign res = res_reg;

endmodule

`default_nettype wire

FILE: rtl/polynomial_multiply_unit.sv
`default_nettype none

// channel | dir | tdata (low bit up)                    | tuser       | tlast
// s_      | in  | coef[31:0]                            | operand_sel | is_last
// m_      | out | prod_coef[31:0], degree_index[37:32]  | overflow    | end_of_product
//
// While loading, a coefficient request is taken as soon as it is offered.
// The second polynomial's last request starts the product: one multiply-accumulate
// per cycle, unless the output stalls, on the shared four-stage multiplier pipeline.
// The whole pipeline holds while a result waits on m_tready.
// No new request is taken until the final product coefficient is delivered.
// Reset (aresetn low, synchronous) empties both polynomials; no clearing pass.

module polynomial_multiply_unit #(
    parameter int MAX_TERMS = pmu_pkg::MAX_TERMS_DEF
) (
    input  wire logic                           aclk,
    input  wire logic                           aresetn,
    input  wire logic                           s_tvalid,
    output logic                                s_tready,
    input  wire logic [pmu_pkg::COEF_W-1:0]     s_tdata,  // coef
    input  wire logic                           s_tuser,  // operand_sel
    input  wire logic                           s_tlast,
    output logic                                m_tvalid,
    input  wire logic                           m_tready,
    output logic [pmu_pkg::M_TDATA_W-1:0]       m_tdata,  // prod_coef, degree_index
    output logic                                m_tuser,  // overflow
    output logic                                m_tlast
);

    localparam int AW = (MAX_TERMS > 1) ? $clog2(MAX_TERMS) : 1;
    localparam int LW = $clog2(MAX_TERMS + 1);
    localparam int DW = pmu_pkg::DEG_W;

    pmu_pkg::pmu_state_t state_reg, state_next;
    logic [DW-1:0] k_reg, k_next;
    logic [AW-1:0] i_reg, i_next;
    logic [LW-1:0] first_len_reg, first_len_next;
    logic [LW-1:0] second_len_reg, second_len_next;
    logic          first_done_reg, first_done_next;
    logic          drop_flag_reg, drop_flag_next;

    logic          s_acc;
    logic          done_acc;
    logic          adv;
    logic          wr_a_en;
    logic          wr_b_en;
    logic [AW-1:0] wr_addr;
    logic [DW-1:0] la_w;
    logic [DW-1:0] lb_w;
    logic [DW-1:0] n_m1;
    logic [DW-1:0] i_w;
    logic [DW-1:0] i_lo;
    logic [DW-1:0] i_hi;
    logic [DW-1:0] k_inc;
    logic [DW-1:0] i_lo_nx;
    logic [DW-1:0] j_w;

    pmu_pkg::pmu_issue_t  issue;
    pmu_pkg::pmu_result_t res;

    assign s_tready = (state_reg == pmu_pkg::ST_LOAD);
    assign s_acc    = s_tvalid && s_tready;
    assign adv      = !res.valid || m_tready;
    assign done_acc = m_tvalid && m_tready && m_tlast;

    always_comb begin
        la_w    = (first_len_reg == '0) ? DW'(1) : DW'(first_len_reg);
        lb_w    = (second_len_reg == '0) ? DW'(1) : DW'(second_len_reg);
        n_m1    = la_w + lb_w - DW'(2);
        i_w     = DW'(i_reg);
        i_lo    = (k_reg >= lb_w) ? k_reg - lb_w + DW'(1) : '0;
        i_hi    = (k_reg < la_w) ? k_reg : la_w - DW'(1);
        k_inc   = k_reg + DW'(1);
        i_lo_nx = (k_inc >= lb_w) ? k_inc - lb_w + DW'(1) : '0;
        j_w     = k_reg - i_w;

        issue.valid = (state_reg == pmu_pkg::ST_RUN);
        issue.first = (i_w == i_lo);
        issue.last  = (i_w == i_hi);
        issue.fin   = (k_reg == n_m1);
        issue.zero  = (first_len_reg == '0) || (second_len_reg == '0);
        issue.deg   = k_reg;

        wr_a_en = s_acc && !s_tuser && !first_done_reg && (first_len_reg < LW'(MAX_TERMS));
        wr_b_en = s_acc && s_tuser && (second_len_reg < LW'(MAX_TERMS));
        wr_addr = s_tuser ? second_len_reg[AW-1:0] : first_len_reg[AW-1:0];
    end

    always_comb begin
        state_next      = state_reg;
        k_next          = k_reg;
        i_next          = i_reg;
        first_len_next  = first_len_reg;
        second_len_next = second_len_reg;
        first_done_next = first_done_reg;
        drop_flag_next  = drop_flag_reg;
        unique case (state_reg)
            pmu_pkg::ST_LOAD: begin
                if (s_acc) begin
                    if (!s_tuser) begin
                        if (wr_a_en) begin
                            first_len_next = first_len_reg + LW'(1);
                        end else begin
                            drop_flag_next = 1'b1;
                        end
                        if (s_tlast) begin
                            first_done_next = 1'b1;
                        end
                    end else begin
                        if (wr_b_en) begin
                            second_len_next = second_len_reg + LW'(1);
                        end else begin
                            drop_flag_next = 1'b1;
                        end
                        if (s_tlast) begin
                            k_next     = '0;
                            i_next     = '0;
                            state_next = pmu_pkg::ST_RUN;
                        end
                    end
                end
            end
            pmu_pkg::ST_RUN: begin
                if (adv) begin
                    if (issue.last) begin
                        if (issue.fin) begin
                            state_next = pmu_pkg::ST_DRAIN;
                        end else begin
                            k_next = k_inc;
                            i_next = i_lo_nx[AW-1:0];
                        end
                    end else begin
                        i_next = i_reg + AW'(1);
                    end
                end
            end
            pmu_pkg::ST_DRAIN: begin
                if (done_acc) begin
                    first_len_next  = '0;
                    second_len_next = '0;
                    first_done_next = 1'b0;
                    drop_flag_next  = 1'b0;
                    state_next      = pmu_pkg::ST_LOAD;
                end
            end
            default: begin
                state_next = pmu_pkg::ST_LOAD;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= pmu_pkg::ST_LOAD;
            k_reg          <= '0;
            i_reg          <= '0;
            first_len_reg  <= '0;
            second_len_reg <= '0;
            first_done_reg <= 1'b0;
            drop_flag_reg  <= 1'b0;
        end else begin
            state_reg      <= state_next;
            k_reg          <= k_next;
            i_reg          <= i_next;
            first_len_reg  <= first_len_next;
            second_len_reg <= second_len_next;
            first_done_reg <= first_done_next;
            drop_flag_reg  <= drop_flag_next;
        end
    end

    pmu_mac #(
        .MAX_TERMS (MAX_TERMS)
    ) u_mac (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .wr_a_en   (wr_a_en),
        .wr_b_en   (wr_b_en),
        .wr_addr   (wr_addr),
        .wr_data   (s_tdata),
        .rd_a_addr (i_reg),
        .rd_b_addr (j_w[AW-1:0]),
        .issue     (issue),
        .adv       (adv),
        .res       (res)
    );

    assign m_tvalid = res.valid;
    assign m_tdata  = {{(pmu_pkg::M_TDATA_W - DW - pmu_pkg::COEF_W){1'b0}}, res.deg, res.coef};
    assign m_tlast  = res.fin;
    assign m_tuser  = res.sat || drop_flag_reg;

    a_idle_no_result: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == pmu_pkg::ST_LOAD) |-> !m_tvalid)
        else $error("result pending while loading");

    a_final_degree: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tlast) |-> (res.deg == n_m1))
        else $error("final coefficient at wrong degree");

    a_len_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        (first_len_reg <= LW'(MAX_TERMS)) && (second_len_reg <= LW'(MAX_TERMS)))
        else $error("store length beyond capacity");

    a_term_range: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == pmu_pkg::ST_RUN) |-> ((i_w >= i_lo) && (i_w <= i_hi)))
        else $error("term index out of range");

endmodule

`default_nettype wire
